// File: sv/msd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants of the motor stall detector.
// ----------------------------------------------------------------------------
package msd_pkg;

   localparam int NUM_MOTORS_DEF    = 8;
   localparam int HISTORY_DEPTH_DEF = 10;

   localparam logic [2:0] REQ_SAMPLE = 3'd0;
   localparam logic [2:0] REQ_TICK   = 3'd1;
   localparam logic [2:0] REQ_ENABLE = 3'd2;
   localparam logic [2:0] REQ_CLEAR  = 3'd3;
   localparam logic [2:0] REQ_LIMITS = 3'd4;

   localparam logic [0:0] CSR_SURGE   = 1'd0;
   localparam logic [0:0] CSR_CONFIRM = 1'd1;

   localparam logic [6:0] SURGE_RESET   = 7'd21;
   localparam logic [7:0] CONFIRM_RESET = 8'd60;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [2:0]         motor;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic [31:0]        timestamp;
      logic               enable_value;
      logic [14:0]        min_avg_limit;
      logic [15:0]        slope_limit;
   } req_type_type;

   typedef struct packed {
      logic [7:0] stall_flags;
      logic [7:0] new_stalls;
      logic       motor_stalled;
      logic [7:0] motor_count;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load;     // capture the request beat
      logic       op_s1;    // first phase of item work
      logic       op_s2;    // second phase of item work
      logic       tick_s1;  // tick: read motor
      logic       tick_s2;  // tick: multiply
      logic       tick_s3;  // tick: compare and update
   } msd_cmd_type;

endpackage

`default_nettype wire

// File: sv/motor_stall_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_stall_detector_core: multi-motor current-surge stall detector.
//
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_stall    req_data  (req_type_type)
// rsp_      out        rsp_valid / rsp_stall    rsp_data  (rsp_type)
// csr_      in         csr_write_enable         csr_index, csr_write_data
//
// A tick walks the motors in order before the result beat, a three-step walk
// per motor (read, multiply, compare and update); other items run op_s1 then op_s2.
// One item is in work at a time; req_stall is high until its result beat
// is taken. A stalled result beat holds. Reset is synchronous and clears
// all motor state at once.
// ----------------------------------------------------------------------------
module motor_stall_detector_core #(
   parameter int NUM_MOTORS    = msd_pkg::NUM_MOTORS_DEF,
   parameter int HISTORY_DEPTH = msd_pkg::HISTORY_DEPTH_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  msd_pkg::req_type_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output msd_pkg::rsp_type       rsp_data,
   input  wire                    csr_write_enable,
   input  wire  [0:0]             csr_index,
   input  wire  [7:0]             csr_write_data
);
   import msd_pkg::*;

   localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   logic [6:0]     surge_ff;
   logic [7:0]     confirm_ff;
   msd_cmd_type    cmd;
   logic           tick_op;
   logic [MIW-1:0] tick_motor;

   always_ff @(posedge clock) begin
      if (reset) begin
         surge_ff   <= SURGE_RESET;
         confirm_ff <= CONFIRM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SURGE:   surge_ff   <= csr_write_data[6:0];
            CSR_CONFIRM: confirm_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   msd_controller #(.NUM_MOTORS(NUM_MOTORS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .tick_op, .cmd, .tick_motor
   );

   msd_datapath #(.NUM_MOTORS(NUM_MOTORS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
      .clock, .reset, .cmd, .req_data,
      .surge_tenths(surge_ff), .confirm_count(confirm_ff), .tick_motor,
      .tick_op, .result(rsp_data)
   );

endmodule

`default_nettype wire

// File: sv/msd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_datapath: per-motor state, history ring and detection arithmetic.
// ----------------------------------------------------------------------------
module msd_datapath #(
   parameter int NUM_MOTORS    = 8,
   parameter int HISTORY_DEPTH = 10,
   localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
   input  wire                     clock,
   input  wire                     reset,
   input  msd_pkg::msd_cmd_type    cmd,
   input  msd_pkg::req_type_type   req_data,
   input  wire  [6:0]              surge_tenths,
   input  wire  [7:0]              confirm_count,
   input  wire  [MIW-1:0]          tick_motor,
   output logic                    tick_op,
   output msd_pkg::rsp_type        result
);
   import msd_pkg::*;

   localparam int PW  = $clog2(HISTORY_DEPTH);
   localparam int RD  = NUM_MOTORS * HISTORY_DEPTH;
   localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
   localparam int SW  = 17 + $clog2(HISTORY_DEPTH);
   localparam logic [PW-1:0] PLAST = PW'(HISTORY_DEPTH - 1);

   req_type_type      q_ff;
   logic signed [15:0] ring_mem [RD];
   logic signed [15:0] ring_rd_ff;
   logic              ring_vld_ff [RD];

   logic [PW-1:0]        ptr_ff   [NUM_MOTORS];
   logic signed [SW-1:0] sum_ff   [NUM_MOTORS];
   logic signed [15:0]   cur_ff   [NUM_MOTORS];
   logic signed [15:0]   spd_ff   [NUM_MOTORS];
   logic [31:0]          time_ff  [NUM_MOTORS];
   logic [1:0]           sign_ff  [NUM_MOTORS];
   logic                 exc_ff   [NUM_MOTORS];
   logic [7:0]           cnt_ff   [NUM_MOTORS];
   logic [NUM_MOTORS-1:0] stl_ff;
   logic [NUM_MOTORS-1:0] ena_ff;
   logic [14:0]          avgf_ff  [NUM_MOTORS];
   logic [15:0]          slpf_ff  [NUM_MOTORS];

   logic [7:0]           fresh_ff;
   logic                 mvalid;
   logic                 sample_op;
   logic [MIW-1:0]       mi;
   logic [RAW-1:0]       raddr;

   // Sample phase registers.
   logic signed [16:0]   dv_ff;
   logic [47:0]          lim_ff;
   logic                 tadv_ff;
   // Tick phase registers.
   logic [MIW-1:0]       ti_ff;
   logic                 tact_ff;
   logic [SW-1:0]        asum_ff;
   logic [15:0]          acur_ff;
   logic signed [1:0]    csgn_ff;
   logic [SW+6:0]        rhs_ff;
   logic [SW+6:0]        lhs_ff;
   logic                 avgok_ff;

   assign mvalid    = 32'(q_ff.motor) < NUM_MOTORS;
   assign mi        = MIW'(q_ff.motor);
   assign sample_op = q_ff.req_type == REQ_SAMPLE && mvalid;
   assign tick_op   = q_ff.req_type == REQ_TICK;
   assign raddr     = RAW'(32'(mi) * HISTORY_DEPTH + 32'(ptr_ff[mi]));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff <= req_data;
      end
      if (cmd.op_s1) begin
         ring_rd_ff <= ring_vld_ff[raddr] ? ring_mem[raddr] : 16'sd0;
         dv_ff      <= 17'(q_ff.speed) - 17'(spd_ff[mi]);
         tadv_ff    <= q_ff.timestamp > time_ff[mi];
         lim_ff     <= 48'(slpf_ff[mi]) * 48'(q_ff.timestamp - time_ff[mi]);
      end
      if (cmd.op_s2 && sample_op) begin
         ring_mem[raddr] <= q_ff.current;
      end
      if (cmd.tick_s1) begin
         ti_ff    <= tick_motor;
         tact_ff  <= ena_ff[tick_motor] && !stl_ff[tick_motor];
         asum_ff  <= sum_ff[tick_motor][SW-1] ? SW'(-sum_ff[tick_motor])
                                                : SW'(sum_ff[tick_motor]);
         acur_ff  <= cur_ff[tick_motor][15] ? 16'(-cur_ff[tick_motor])
                                              : 16'(cur_ff[tick_motor]);
         csgn_ff  <= cur_ff[tick_motor] > 0 ? 2'sd1
                   : (cur_ff[tick_motor] < 0 ? -2'sd1 : 2'sd0);
      end
      if (cmd.tick_s2) begin
         rhs_ff   <= (SW+7)'(asum_ff) * (SW+7)'(surge_tenths);
         lhs_ff   <= (SW+7)'(acur_ff) * (SW+7)'(HISTORY_DEPTH) * (SW+7)'(10);
         avgok_ff <= (SW+7)'(asum_ff) >
                     (SW+7)'(avgf_ff[ti_ff]) * (SW+7)'(HISTORY_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RD; i++) ring_vld_ff[i] <= 1'b0;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            ptr_ff[i] <= '0; sum_ff[i] <= '0; cur_ff[i] <= '0; spd_ff[i] <= '0;
            time_ff[i] <= '0; sign_ff[i] <= '0; exc_ff[i] <= 1'b0; cnt_ff[i] <= '0;
            avgf_ff[i] <= '0; slpf_ff[i] <= '0;
         end
         stl_ff   <= '0;
         ena_ff   <= '0;
         fresh_ff <= '0;
      end else begin
         if (cmd.load) fresh_ff <= '0;
         if (cmd.op_s2 && mvalid && !tick_op) begin
            case (q_ff.req_type)
               REQ_SAMPLE: begin
                  ring_vld_ff[raddr] <= 1'b1;
                  if (tadv_ff) begin
                     sign_ff[mi] <= dv_ff > 0 ? 2'd1 : (dv_ff < 0 ? 2'd3 : 2'd0);
                     exc_ff[mi]  <= 48'(dv_ff[16] ? -dv_ff : dv_ff) > lim_ff;
                  end else begin
                     sign_ff[mi] <= 2'd0;
                     exc_ff[mi]  <= 1'b0;
                  end
                  spd_ff[mi]  <= q_ff.speed;
                  time_ff[mi] <= q_ff.timestamp;
                  cur_ff[mi]  <= q_ff.current;
                  sum_ff[mi]  <= sum_ff[mi] + SW'(q_ff.current) - SW'(ring_rd_ff);
                  ptr_ff[mi]  <= (ptr_ff[mi] == PLAST) ? '0 : ptr_ff[mi] + 1'b1;
               end
               REQ_ENABLE: begin
                  ena_ff[mi] <= q_ff.enable_value;
                  if (!q_ff.enable_value) stl_ff[mi] <= 1'b0;
               end
               REQ_CLEAR: stl_ff[mi] <= 1'b0;
               REQ_LIMITS: begin
                  avgf_ff[mi] <= q_ff.min_avg_limit;
                  slpf_ff[mi] <= q_ff.slope_limit;
               end
               default: ;
            endcase
         end
         if (cmd.tick_s3 && tact_ff) begin
            if (avgok_ff && lhs_ff > rhs_ff &&
                ((csgn_ff == 2'sd1 && sign_ff[ti_ff] == 2'd3) ||
                 (csgn_ff == -2'sd1 && sign_ff[ti_ff] == 2'd1))) begin
               if (slpf_ff[ti_ff] == 16'd0 || exc_ff[ti_ff]) begin
                  logic [7:0] nc;
                  nc = (cnt_ff[ti_ff] != 8'hFF) ? cnt_ff[ti_ff] + 8'd1 : cnt_ff[ti_ff];
                  cnt_ff[ti_ff] <= nc;
                  if (nc >= confirm_count) begin
                     stl_ff[ti_ff] <= 1'b1;
                     if (32'(ti_ff) < 8) fresh_ff[3'(ti_ff)] <= 1'b1;
                  end
               end
            end else if (cnt_ff[ti_ff] != 8'd0) begin
               cnt_ff[ti_ff] <= cnt_ff[ti_ff] - 8'd1;
            end
         end
      end
   end

   always_comb begin
      result = '0;
      for (int i = 0; i < NUM_MOTORS && i < 8; i++) result.stall_flags[i] = stl_ff[i];
      result.new_stalls    = fresh_ff;
      result.motor_stalled = mvalid && stl_ff[mi];
      result.motor_count   = mvalid ? cnt_ff[mi] : 8'd0;
   end

endmodule

`default_nettype wire

// File: sv/msd_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msd_controller: sequences one item at a time and holds the result beat.
// ----------------------------------------------------------------------------
module msd_controller #(
   parameter int NUM_MOTORS = 8,
   localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   input  wire                   tick_op,
   output msd_pkg::msd_cmd_type  cmd,
   output logic [MIW-1:0]        tick_motor
);
   import msd_pkg::*;

   localparam logic [MIW-1:0] MLAST = MIW'(NUM_MOTORS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_S1   = 3'd1;
   localparam logic [2:0] ST_S2   = 3'd2;
   localparam logic [2:0] ST_T1   = 3'd3;
   localparam logic [2:0] ST_T2   = 3'd4;
   localparam logic [2:0] ST_T3   = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [MIW-1:0] idx_ff, idx_in;

   assign tick_motor = idx_ff;
   assign req_stall  = state_ff != ST_IDLE;
   assign rsp_valid  = state_ff == ST_OUT;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_S1;
         end
         ST_S1: begin
            cmd.op_s1 = 1'b1;
            idx_in    = '0;
            state_in  = tick_op ? ST_T1 : ST_S2;
         end
         ST_S2: begin
            cmd.op_s2 = 1'b1;
            state_in  = ST_OUT;
         end
         ST_T1: begin
            cmd.tick_s1 = 1'b1;
            state_in    = ST_T2;
         end
         ST_T2: begin
            cmd.tick_s2 = 1'b1;
            state_in    = ST_T3;
         end
         ST_T3: begin
            cmd.tick_s3 = 1'b1;
            if (idx_ff == MLAST) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_T1;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("accepting while result pending");
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T3 && idx_ff == MLAST) |=> rsp_valid)
      else $error("tick walk did not finish");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for motor_stall_detector_core.
//
// Requests are driven as beats with random gaps and the result channel is
// stalled at random. A behavioral model of the detector predicts each result
// beat, and the beats are compared in order. A short table of
// directed beats opens the run, then surge stimulus builds up stall
// conditions on the motors under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
   import msd_pkg::*;

   localparam int MOTORS = 8;
   localparam int DEPTH  = 10;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = CSR_SURGE;
   logic [7:0] csr_write_data = '0;

   motor_stall_detector_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Detector state mirror.
   logic [6:0]         surge_reg;
   logic [7:0]         confirm_reg;
   logic signed [15:0] hist [MOTORS][DEPTH];
   int                 hist_pos [MOTORS];
   logic signed [19:0] hist_sum [MOTORS];
   logic signed [15:0] last_cur [MOTORS];
   logic signed [15:0] prev_speed [MOTORS];
   logic [31:0]        last_time [MOTORS];
   int                 speed_dir [MOTORS];
   logic               speed_fast [MOTORS];
   logic [7:0]         debounce [MOTORS];
   logic               flagged [MOTORS];
   logic               active [MOTORS];
   logic [14:0]        avg_min [MOTORS];
   logic [15:0]        slope_min [MOTORS];

   rsp_type expected_beats [$];
   int mismatches = 0;
   bit timed_out = 1'b0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   int rsp_wait_max = 3;

   task automatic clear_mirror();
      surge_reg = SURGE_RESET;
      confirm_reg = CONFIRM_RESET;
      for (int m = 0; m < MOTORS; m++) begin
         for (int d = 0; d < DEPTH; d++) hist[m][d] = '0;
         hist_pos[m] = 0; hist_sum[m] = '0; last_cur[m] = '0; prev_speed[m] = '0;
         last_time[m] = '0; speed_dir[m] = 0; speed_fast[m] = 1'b0;
         debounce[m] = '0; flagged[m] = 1'b0; active[m] = 1'b0;
         avg_min[m] = '0; slope_min[m] = '0;
      end
   endtask

   function automatic rsp_type predict_detector(req_type_type r);
      rsp_type o;
      logic [7:0] fresh;
      longint dv, asum, acur;
      int csign;
      bit cond;
      int m;
      fresh = '0;
      m = int'(r.motor);
      case (r.req_type)
         REQ_SAMPLE: begin
            dv = longint'(r.speed) - longint'(prev_speed[m]);
            if (r.timestamp > last_time[m]) begin
               speed_dir[m] = dv > 0 ? 1 : (dv < 0 ? -1 : 0);
               speed_fast[m] = ((dv < 0) ? -dv : dv) >
                               longint'(slope_min[m]) * longint'(r.timestamp - last_time[m]);
            end else begin
               speed_dir[m] = 0;
               speed_fast[m] = 1'b0;
            end
            prev_speed[m] = r.speed;
            last_time[m] = r.timestamp;
            last_cur[m] = r.current;
            hist_sum[m] = hist_sum[m] + r.current - hist[m][hist_pos[m]];
            hist[m][hist_pos[m]] = r.current;
            hist_pos[m] = (hist_pos[m] + 1) % DEPTH;
         end
         REQ_TICK: begin
            for (int i = 0; i < MOTORS; i++) begin
               if (active[i] && !flagged[i]) begin
                  asum = hist_sum[i] < 0 ? -longint'(hist_sum[i]) : longint'(hist_sum[i]);
                  acur = last_cur[i] < 0 ? -longint'(last_cur[i]) : longint'(last_cur[i]);
                  csign = last_cur[i] > 0 ? 1 : (last_cur[i] < 0 ? -1 : 0);
                  cond = asum > longint'(avg_min[i]) * DEPTH &&
                         acur * DEPTH * 10 > asum * longint'(surge_reg) &&
                         csign * speed_dir[i] < 0;
                  if (cond) begin
                     if (slope_min[i] == 0 || speed_fast[i]) begin
                        if (debounce[i] < 8'd255) debounce[i]++;
                        if (debounce[i] >= confirm_reg) begin
                           flagged[i] = 1'b1;
                           fresh[i] = 1'b1;
                        end
                     end
                  end else if (debounce[i] > 0) begin
                     debounce[i]--;
                  end
               end
            end
         end
         REQ_ENABLE: begin
            active[m] = r.enable_value;
            if (!r.enable_value) flagged[m] = 1'b0;
         end
         REQ_CLEAR: flagged[m] = 1'b0;
         REQ_LIMITS: begin
            avg_min[m] = r.min_avg_limit;
            slope_min[m] = r.slope_limit;
         end
         default: ;
      endcase
      for (int i = 0; i < MOTORS; i++) o.stall_flags[i] = flagged[i];
      o.new_stalls = fresh;
      o.motor_stalled = flagged[m];
      o.motor_count = debounce[m];
      return o;
   endfunction

   // Result side: random stalls and in-order comparison.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_data);
         end else begin
            rsp_type e;
            e = expected_beats.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected flags %h new %h stalled %b count %0d, got flags %h new %h stalled %b count %0d",
                           e.stall_flags, e.new_stalls, e.motor_stalled, e.motor_count,
                           rsp_data.stall_flags, rsp_data.new_stalls,
                           rsp_data.motor_stalled, rsp_data.motor_count);
            end
         end
      end
      if (hold_rsp) rsp_stall <= 1'b1;
      else if ($urandom_range(99) < 25) rsp_stall <= 1'b1;
      else if ($urandom_range(99) < 2) rsp_stall <= ($urandom_range(1) == 1);
      else rsp_stall <= ($urandom_range(rsp_wait_max) == 0) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("motor_stall_detector_core regression: fail");
         $finish;
      end
   end

   task automatic send_beat(req_type_type r, bit gaps);
      int g;
      if (gaps) begin
         g = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
         if ($urandom_range(3) == 0) g = 0;
         repeat (g) @(posedge clock);
      end
      @(posedge clock);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_beats.push_back(predict_detector(r));
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (expected_beats.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [7:0] val);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_SURGE) surge_reg = val[6:0];
      else confirm_reg = val;
   endtask

   function automatic req_type_type make_req(logic [2:0] kind, logic [2:0] m);
      req_type_type r;
      r = '0;
      r.req_type = kind;
      r.motor = m;
      r.speed = 16'($urandom);
      r.current = 16'($urandom);
      r.timestamp = $urandom;
      r.enable_value = 1'($urandom);
      r.min_avg_limit = 15'($urandom);
      r.slope_limit = 16'($urandom);
      return r;
   endfunction

   logic [31:0] clock_ticks [MOTORS];

   // Build a sample that tends to produce a surge against the speed slope.
   function automatic req_type_type surge_sample(logic [2:0] m);
      req_type_type r;
      int sgn;
      r = make_req(REQ_SAMPLE, m);
      sgn = ($urandom_range(1) == 1) ? 1 : -1;
      clock_ticks[m] = clock_ticks[m] + $urandom_range(($urandom_range(7) == 0) ? 0 : 1, 5);
      r.timestamp = clock_ticks[m];
      case ($urandom_range(5))
         0, 1: r.current = 16'(sgn * $urandom_range(100, 300));
         2, 3: r.current = 16'(sgn * $urandom_range(1500, 32000));
         4: r.current = 16'(-sgn * $urandom_range(3000, 32000));
         default: ;
      endcase
      r.speed = prev_speed[m] + 16'(-sgn * $urandom_range(0, 3000));
      return r;
   endfunction

   typedef struct {
      req_type_type r;
      bit           known;
      rsp_type      want;
   } table_row_type;

   function automatic table_row_type row(logic [2:0] kind, logic [2:0] m,
                                         logic signed [15:0] spd,
                                         logic signed [15:0] cur, logic [31:0] ts, logic en,
                                         logic [14:0] amin, logic [15:0] smin, bit known,
                                         rsp_type want);
      table_row_type t;
      t.r = '{req_type: kind, motor: m, speed: spd, current: cur, timestamp: ts,
              enable_value: en, min_avg_limit: amin, slope_limit: smin};
      t.known = known;
      t.want = want;
      return t;
   endfunction

   initial begin
      table_row_type rows [$];
      rsp_type got;
      req_type_type r;
      int phase_surge [5];
      int phase_confirm [5];
      phase_surge = '{10, 100, 21, 15, 40};
      phase_confirm = '{1, 255, 0, 3, 8};
      clear_mirror();
      for (int m = 0; m < MOTORS; m++) clock_ticks[m] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; the leading rows carry fixed expectations right after reset.
      rows.push_back(row(REQ_TICK, 3'd0, 0, 0, 0, 0, 0, 0, 1, '0));
      rows.push_back(row(REQ_CLEAR, 3'd7, 0, 0, 0, 0, 0, 0, 1, '0));
      rows.push_back(row(3'd5, 3'd2, 0, 0, 0, 0, 0, 0, 1, '0));
      rows.push_back(row(3'd6, 3'd5, -1, -1, '1, 1, '1, '1, 1, '0));
      rows.push_back(row(3'd7, 3'd1, 0, 0, 0, 1, 0, 0, 1, '0));
      rows.push_back(row(REQ_LIMITS, 3'd7, 0, 0, 0, 0, 15'h7fff, 16'hffff, 1, '0));
      rows.push_back(row(REQ_LIMITS, 3'd0, 0, 0, 0, 0, 0, 0, 1, '0));
      rows.push_back(row(REQ_ENABLE, 3'd0, 0, 0, 0, 1, 0, 0, 1, '0));
      rows.push_back(row(REQ_SAMPLE, 3'd0, 16'sh7fff, 16'sh7fff, 32'd0, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_SAMPLE, 3'd0, 16'sh8000, 16'sh8000, '1, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_SAMPLE, 3'd0, 16'sd1000, 16'sd2000, '1, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_SAMPLE, 3'd0, 16'sd0, 16'sd30000, 32'd5, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_SAMPLE, 3'd7, -16'sd5, -16'sd4000, 32'd9, 1, 0, 0, 0, '0));
      rows.push_back(row(REQ_TICK, 3'd0, 0, 0, 0, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_TICK, 3'd4, 0, 0, 0, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_CLEAR, 3'd0, 0, 0, 0, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_ENABLE, 3'd7, 0, 0, 0, 1, 0, 0, 0, '0));
      rows.push_back(row(REQ_ENABLE, 3'd0, 0, 0, 0, 0, 0, 0, 0, '0));
      rows.push_back(row(REQ_LIMITS, 3'd3, 0, 0, 0, 0, 15'h5555, 16'haaaa, 0, '0));
      rows.push_back(row(REQ_LIMITS, 3'd3, 0, 0, 0, 0, 15'h2aaa, 16'h5555, 0, '0));
      foreach (rows[i]) begin
         send_beat(rows[i].r, 1'b1);
         if (rows[i].known) begin
            got = expected_beats[$];
            if (got !== rows[i].want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row %0d: expected %h, predicted %h", i, rows[i].want, got);
            end
         end
      end
      drain();
      for (int m = 0; m < MOTORS; m++) clock_ticks[m] = last_time[m];

      // Random phases, each under one register setting.
      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_SURGE, 8'(phase_surge[p]));
         write_csr(CSR_CONFIRM, 8'(phase_confirm[p]));
         for (int m = 0; m < MOTORS; m++) begin
            r = make_req(REQ_LIMITS, 3'(m));
            r.min_avg_limit = ($urandom_range(3) == 0) ? 15'($urandom)
                                                       : 15'($urandom_range(200));
            r.slope_limit = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(600));
            if (p == 4 && m == 0) begin
               r.min_avg_limit = '1;
               r.slope_limit = '1;
            end
            send_beat(r, 1'b1);
            r = make_req(REQ_ENABLE, 3'(m));
            r.enable_value = ($urandom_range(7) != 0);
            send_beat(r, 1'b1);
         end
         for (int n = 0; n < 270; n++) begin
            int k;
            k = $urandom_range(99);
            if (p == 1 && n == 100) begin
               // Long receiver hold-off while requests keep coming.
               fork
                  begin
                     hold_rsp = 1'b1;
                     repeat (300) @(posedge clock);
                     hold_rsp = 1'b0;
                  end
               join_none
            end
            if (p == 2 && n == 50) wait (expected_beats.size() == 0);
            rsp_wait_max = (n % 90 < 30) ? 0 : 3;
            if (k < 55) r = surge_sample(3'($urandom_range(MOTORS - 1)));
            else if (k < 80) r = make_req(REQ_TICK, 3'($urandom));
            else if (k < 86) r = make_req(REQ_CLEAR, 3'($urandom));
            else if (k < 91) begin
               r = make_req(REQ_ENABLE, 3'($urandom));
               r.enable_value = ($urandom_range(3) != 0);
            end else if (k < 95) r = make_req(REQ_LIMITS, 3'($urandom));
            else if (k < 97) r = make_req(3'($urandom_range(5, 7)), 3'($urandom));
            else begin
               r = make_req(REQ_SAMPLE, 3'($urandom));
               clock_ticks[r.motor] = r.timestamp;
            end
            send_beat(r, (n % 70) > 20);
         end
      end
      rsp_wait_max = 3;
      drain();
      if (mismatches == 0) $display("motor_stall_detector_core regression: pass");
      else $display("motor_stall_detector_core regression: fail");
      $finish;
   end

endmodule
